// ===== sv/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, off while reset is asserted
`define MLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication check
`define MLS_ASSERT_IMP(name, ante, cons, msg) \
  `MLS_ASSERT(name, (ante) |-> (cons), msg)

`endif

// ===== sv/moesi_pkg.sv =====
// package with types, codes and sizes of the moesi line state machine
`default_nettype none

package moesi_pkg;

  localparam int NUM_SETS    = 1024;
  localparam int NUM_WAYS    = 8;
  localparam int NUM_LINES   = NUM_SETS * NUM_WAYS;
  localparam int LINE_AW     = $clog2(NUM_LINES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_PROC_READ   = 3'd0,
    ACT_PROC_IREAD  = 3'd1,
    ACT_PROC_WRITE  = 3'd2,
    ACT_SNOOP_READ  = 3'd3,
    ACT_SNOOP_WRITE = 3'd4,
    ACT_SNOOP_RWIM  = 3'd5,
    ACT_SNOOP_INV   = 3'd6,
    ACT_RESERVED    = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_I = 3'd0,
    ST_S = 3'd1,
    ST_E = 3'd2,
    ST_O = 3'd3,
    ST_M = 3'd4
  } line_state_e;

  typedef enum logic [2:0] {
    BUS_NONE  = 3'd0,
    BUS_READ  = 3'd1,
    BUS_WRITE = 3'd2,
    BUS_INV   = 3'd3,
    BUS_RWIM  = 3'd4
  } bus_op_e;

  typedef enum logic [1:0] {
    SR_NONE  = 2'd0,
    SR_HIT   = 2'd1,
    SR_HITM  = 2'd2,
    SR_NOHIT = 2'd3
  } snoop_resp_e;

  typedef enum logic [1:0] {
    OTHERS_NOHIT = 2'd0,
    OTHERS_HIT   = 2'd1,
    OTHERS_HITM  = 2'd2,
    OTHERS_SPARE = 2'd3
  } others_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    logic [2:0] action;
    logic [9:0] set_index;
    logic [2:0] way;
    logic [1:0] others_snoop_result;
  } req_t;

  typedef struct packed {
    logic [2:0] bus_cmd;
    logic [1:0] snoop_reply;
    logic       line_lost;
    logic       bad_transition;
    logic [2:0] next_line_state;
  } rsp_t;

  typedef struct packed {
    action_e              act;
    logic [LINE_AW-1:0]   line_idx;
    logic                 out_of_range;
    logic                 others_hit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/moesi_front.sv =====
// front end: takes requests and classifies them into commands
`default_nettype none

module moesi_front import moesi_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  input  wire  req_t in_req_i,
  input  wire  logic clearing_i,
  output logic       push_valid_o,
  input  wire  logic push_ready_i,
  output cmd_t       push_cmd_o
);

  logic [31:0] idx_wide;
  logic        busy_q;

  // hold off requests for the cycle after the clearing pass ends as well
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= clearing_i;
    end
  end

  always_comb begin
    idx_wide = 32'(in_req_i.set_index) * 32'(NUM_WAYS) + 32'(in_req_i.way);
    push_cmd_o.act          = action_e'(in_req_i.action);
    push_cmd_o.line_idx     = idx_wide[LINE_AW-1:0];
    push_cmd_o.out_of_range = (32'(in_req_i.set_index) >= 32'(NUM_SETS)) ||
                              (32'(in_req_i.way) >= 32'(NUM_WAYS));
    push_cmd_o.others_hit   = (in_req_i.others_snoop_result == OTHERS_HIT) ||
                              (in_req_i.others_snoop_result == OTHERS_HITM);
  end

  assign in_ready_o   = push_ready_i && !clearing_i && !busy_q;
  assign push_valid_o = in_valid_i && !clearing_i && !busy_q;

endmodule

`default_nettype wire

// ===== sv/moesi_queue.sv =====
// short command queue between front and back end
`default_nettype none

module moesi_queue import moesi_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic push_valid_i,
  output logic       push_ready_o,
  input  wire  cmd_t push_cmd_i,
  output logic       pop_valid_o,
  input  wire  logic pop_ready_i,
  output cmd_t       pop_cmd_o
);

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/moesi_back.sv =====
// back end: line state memory, clearing pass, transition logic, result register
`default_nettype none

module moesi_back import moesi_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic pop_valid_i,
  output logic       pop_ready_o,
  input  wire  cmd_t pop_cmd_i,
  output logic       clearing_o,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  output rsp_t       out_rsp_o
);

  logic [2:0]         line_mem_q [NUM_LINES];
  logic [2:0]         rd_q;
  back_state_e        state_q, state_d;
  logic [LINE_AW-1:0] clr_q, clr_d;
  cmd_t               cmd_q, cmd_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_rsp_q, out_rsp_d;
  rsp_t               nxt_rsp;
  logic               rd_en, wr_en;
  logic [LINE_AW-1:0] wr_addr;
  logic [2:0]         wr_data;

  // transition of one line
  always_comb begin
    logic       is_read;
    logic [2:0] nst;
    nxt_rsp = '0;
    is_read = (cmd_q.act == ACT_PROC_READ) || (cmd_q.act == ACT_PROC_IREAD);
    nst     = rd_q;
    unique case (rd_q)
      ST_I: begin
        priority if (is_read) begin
          nxt_rsp.bus_cmd = BUS_READ;
          nst = cmd_q.others_hit ? ST_S : ST_E;
        end else if (cmd_q.act == ACT_PROC_WRITE) begin
          nxt_rsp.bus_cmd = BUS_RWIM;
          nst = ST_M;
        end else if (cmd_q.act != ACT_RESERVED) begin
          nxt_rsp.snoop_reply = SR_NOHIT;
        end else begin
          nxt_rsp.bad_transition = 1'b1;
        end
      end
      ST_S: begin
        priority if (is_read) begin
        end else if (cmd_q.act == ACT_PROC_WRITE) begin
          nxt_rsp.bus_cmd = BUS_INV;
          nst = ST_M;
        end else if (cmd_q.act == ACT_SNOOP_READ) begin
          nxt_rsp.snoop_reply = SR_HIT;
        end else if (cmd_q.act == ACT_SNOOP_RWIM || cmd_q.act == ACT_SNOOP_INV) begin
          nxt_rsp.snoop_reply = SR_NOHIT;
          nxt_rsp.line_lost = 1'b1;
          nst = ST_I;
        end else begin
          nxt_rsp.bad_transition = 1'b1;
        end
      end
      ST_E: begin
        priority if (is_read) begin
        end else if (cmd_q.act == ACT_PROC_WRITE) begin
          nst = ST_M;
        end else if (cmd_q.act == ACT_SNOOP_READ) begin
          nxt_rsp.snoop_reply = SR_HIT;
          nst = ST_S;
        end else if (cmd_q.act == ACT_SNOOP_RWIM) begin
          nxt_rsp.snoop_reply = SR_NOHIT;
          nxt_rsp.line_lost = 1'b1;
          nst = ST_I;
        end else begin
          nxt_rsp.bad_transition = 1'b1;
        end
      end
      ST_O: begin
        priority if (is_read) begin
        end else if (cmd_q.act == ACT_PROC_WRITE) begin
          nst = ST_M;
        end else if (cmd_q.act == ACT_SNOOP_READ) begin
          nxt_rsp.snoop_reply = SR_HITM;
          nxt_rsp.bus_cmd = BUS_WRITE;
        end else if (cmd_q.act == ACT_SNOOP_RWIM) begin
          nxt_rsp.snoop_reply = SR_HITM;
          nxt_rsp.bus_cmd = BUS_WRITE;
          nxt_rsp.line_lost = 1'b1;
          nst = ST_I;
        end else begin
          nxt_rsp.bad_transition = 1'b1;
        end
      end
      ST_M: begin
        priority if (is_read || cmd_q.act == ACT_PROC_WRITE) begin
        end else if (cmd_q.act == ACT_SNOOP_READ) begin
          nxt_rsp.snoop_reply = SR_HITM;
          nxt_rsp.bus_cmd = BUS_WRITE;
          nst = ST_O;
        end else if (cmd_q.act == ACT_SNOOP_RWIM) begin
          nxt_rsp.snoop_reply = SR_HITM;
          nxt_rsp.bus_cmd = BUS_WRITE;
          nxt_rsp.line_lost = 1'b1;
          nst = ST_I;
        end else begin
          nxt_rsp.bad_transition = 1'b1;
        end
      end
      default: begin
        nxt_rsp.bad_transition = 1'b1;
        nst = ST_I;
      end
    endcase
    nxt_rsp.next_line_state = nst;
    if (cmd_q.out_of_range) begin
      nxt_rsp = '0;
      nxt_rsp.bad_transition = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    pop_ready_o = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = cmd_q.line_idx;
    wr_data     = nxt_rsp.next_line_state;
    unique case (state_q)
      BK_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = ST_I;
        clr_d   = clr_q + LINE_AW'(1);
        if (clr_q == LINE_AW'(NUM_LINES - 1)) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          rd_en   = 1'b1;
          cmd_d   = pop_cmd_i;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          wr_en       = !cmd_q.out_of_range;
          out_valid_d = 1'b1;
          out_rsp_d   = nxt_rsp;
          state_d     = BK_FETCH;
        end
      end
      default: begin
        state_d = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    out_rsp_q <= out_rsp_d;
  end

  // line state memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= line_mem_q[pop_cmd_i.line_idx];
    end
  end

  assign clearing_o  = (state_q == BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ===== sv/moesi_line_state_machine.sv =====
// top level of the moesi line state machine
// a request is queued, its line state read into a register, and its result
//   registered; the back end takes a new request only after the line state
//   memory has been read then written for the last one
// reset: after rst_ni releases, a clearing pass over the NUM_LINES (8192) lines
//   sets each to invalid; in_ready_o stays low through it and the cycle after
`default_nettype none
`include "assert_macros.svh"

module moesi_line_state_machine import moesi_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  input  wire  req_t in_req_i,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  output rsp_t       out_rsp_o
);

  logic clearing;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  moesi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .clearing_i   (clearing),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  moesi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  moesi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  `MLS_ASSERT_IMP(a_no_result_while_clearing, clearing, !out_valid_o && !pop_ready,
                  "result or pop during clearing pass")
  `MLS_ASSERT_IMP(a_lost_line_goes_invalid, out_valid_o && out_rsp_o.line_lost,
                  out_rsp_o.next_line_state == ST_I && !out_rsp_o.bad_transition,
                  "lost line not invalid")
  `MLS_ASSERT_IMP(a_bad_request_is_quiet, out_valid_o && out_rsp_o.bad_transition,
                  out_rsp_o.bus_cmd == BUS_NONE && out_rsp_o.snoop_reply == SR_NONE &&
                  !out_rsp_o.line_lost, "bad request drove outputs")

endmodule

`default_nettype wire

// ===== bench/moesi_line_state_machine_checker.sv =====
`timescale 1ns / 100ps
// checker for the moesi line state machine: watches both channels, predicts and compares

module moesi_line_state_machine_checker import moesi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  req_t        in_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rsp_t        out_rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  line_state_e line_tbl [NUM_LINES];
  rsp_t        expected_rsp_q [$];

  function automatic rsp_t coherence_response(line_state_e cur, req_t r);
    rsp_t    rsp;
    action_e act;
    logic    rd;
    logic    others_hold;
    rsp = '0;
    rsp.next_line_state = cur;
    act = action_e'(r.action);
    rd = (act == ACT_PROC_READ) || (act == ACT_PROC_IREAD);
    others_hold = (r.others_snoop_result == OTHERS_HIT) ||
                  (r.others_snoop_result == OTHERS_HITM);
    unique case (cur)
      ST_I: begin
        if (rd) begin
          rsp.bus_cmd = BUS_READ;
          rsp.next_line_state = others_hold ? ST_S : ST_E;
        end else if (act == ACT_PROC_WRITE) begin
          rsp.bus_cmd = BUS_RWIM;
          rsp.next_line_state = ST_M;
        end else if (act == ACT_SNOOP_READ || act == ACT_SNOOP_WRITE ||
                     act == ACT_SNOOP_RWIM || act == ACT_SNOOP_INV) begin
          rsp.snoop_reply = SR_NOHIT;
        end else begin
          rsp.bad_transition = 1'b1;
        end
      end
      ST_S: begin
        if (rd) begin
        end else if (act == ACT_PROC_WRITE) begin
          rsp.bus_cmd = BUS_INV;
          rsp.next_line_state = ST_M;
        end else if (act == ACT_SNOOP_READ) begin
          rsp.snoop_reply = SR_HIT;
        end else if (act == ACT_SNOOP_RWIM || act == ACT_SNOOP_INV) begin
          rsp.snoop_reply = SR_NOHIT;
          rsp.next_line_state = ST_I;
          rsp.line_lost = 1'b1;
        end else begin
          rsp.bad_transition = 1'b1;
        end
      end
      ST_E: begin
        if (rd) begin
        end else if (act == ACT_PROC_WRITE) begin
          rsp.next_line_state = ST_M;
        end else if (act == ACT_SNOOP_READ) begin
          rsp.snoop_reply = SR_HIT;
          rsp.next_line_state = ST_S;
        end else if (act == ACT_SNOOP_RWIM) begin
          rsp.snoop_reply = SR_NOHIT;
          rsp.next_line_state = ST_I;
          rsp.line_lost = 1'b1;
        end else begin
          rsp.bad_transition = 1'b1;
        end
      end
      ST_O: begin
        if (rd) begin
        end else if (act == ACT_PROC_WRITE) begin
          rsp.next_line_state = ST_M;
        end else if (act == ACT_SNOOP_READ) begin
          rsp.snoop_reply = SR_HITM;
          rsp.bus_cmd = BUS_WRITE;
        end else if (act == ACT_SNOOP_RWIM) begin
          rsp.snoop_reply = SR_HITM;
          rsp.bus_cmd = BUS_WRITE;
          rsp.next_line_state = ST_I;
          rsp.line_lost = 1'b1;
        end else begin
          rsp.bad_transition = 1'b1;
        end
      end
      ST_M: begin
        if (rd || act == ACT_PROC_WRITE) begin
        end else if (act == ACT_SNOOP_READ) begin
          rsp.snoop_reply = SR_HITM;
          rsp.bus_cmd = BUS_WRITE;
          rsp.next_line_state = ST_O;
        end else if (act == ACT_SNOOP_RWIM) begin
          rsp.snoop_reply = SR_HITM;
          rsp.bus_cmd = BUS_WRITE;
          rsp.next_line_state = ST_I;
          rsp.line_lost = 1'b1;
        end else begin
          rsp.bad_transition = 1'b1;
        end
      end
      default: begin
        rsp.bad_transition = 1'b1;
        rsp.next_line_state = ST_I;
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i) begin : watch
    rsp_t exp_rsp;
    int   idx;
    int   bad_fields;
    if (!rst_ni) begin
      foreach (line_tbl[i]) line_tbl[i] = ST_I;
      expected_rsp_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (in_req_i.set_index >= NUM_SETS || in_req_i.way >= NUM_WAYS) begin
          exp_rsp = '0;
          exp_rsp.bad_transition = 1'b1;
        end else begin
          idx = int'(in_req_i.set_index) * NUM_WAYS + int'(in_req_i.way);
          exp_rsp = coherence_response(line_tbl[idx], in_req_i);
          line_tbl[idx] = line_state_e'(exp_rsp.next_line_state);
        end
        expected_rsp_q.push_back(exp_rsp);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          bad_fields = 0;
          if (out_rsp_i.bus_cmd !== exp_rsp.bus_cmd) begin
            $error("bus_cmd: expected %0d, actual %0d",
                   exp_rsp.bus_cmd, out_rsp_i.bus_cmd);
            bad_fields++;
          end
          if (out_rsp_i.snoop_reply !== exp_rsp.snoop_reply) begin
            $error("snoop_reply: expected %0d, actual %0d",
                   exp_rsp.snoop_reply, out_rsp_i.snoop_reply);
            bad_fields++;
          end
          if (out_rsp_i.line_lost !== exp_rsp.line_lost) begin
            $error("line_lost: expected %0d, actual %0d",
                   exp_rsp.line_lost, out_rsp_i.line_lost);
            bad_fields++;
          end
          if (out_rsp_i.bad_transition !== exp_rsp.bad_transition) begin
            $error("bad_transition: expected %0d, actual %0d",
                   exp_rsp.bad_transition, out_rsp_i.bad_transition);
            bad_fields++;
          end
          if (out_rsp_i.next_line_state !== exp_rsp.next_line_state) begin
            $error("next_line_state: expected %0d, actual %0d",
                   exp_rsp.next_line_state, out_rsp_i.next_line_state);
            bad_fields++;
          end
          fail_count_o <= fail_count_o + bad_fields;
        end
      end
      pending_o <= expected_rsp_q.size();
    end
  end

endmodule

// ===== bench/moesi_line_state_machine_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the moesi line state machine: clock, reset, requests, idling and verdict

module moesi_line_state_machine_tb;
  import moesi_pkg::*;

  localparam int PHASE_ITEMS = 235;
  localparam int POOL_SIZE   = 12;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  req_t        in_req    = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_rsp;
  int unsigned fail_count;
  int unsigned pending;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic [9:0]  pool_set [POOL_SIZE];
  logic [2:0]  pool_way [POOL_SIZE];

  always #4 clk_i = ~clk_i;

  moesi_line_state_machine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  moesi_line_state_machine_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic req_t mk_req(action_e act, logic [9:0] set_idx, logic [2:0] way,
                                  logic [1:0] others);
    req_t r;
    r.action = act;
    r.set_index = set_idx;
    r.way = way;
    r.others_snoop_result = others;
    return r;
  endfunction

  task automatic send_req(req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    req_t directed [$];
    req_t r;
    int   pick;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_set[i] = 10'($urandom_range(1023));
      pool_way[i] = 3'($urandom_range(7));
    end

    // one line walked through every state, then the far corner line
    directed.push_back(mk_req(ACT_SNOOP_READ,  10'd0, 3'd0, OTHERS_HITM));
    directed.push_back(mk_req(ACT_RESERVED,    10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_PROC_READ,   10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_WRITE, 10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_INV,   10'd0, 3'd0, OTHERS_HIT));
    directed.push_back(mk_req(ACT_SNOOP_READ,  10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_PROC_IREAD,  10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_WRITE, 10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_INV,   10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_PROC_IREAD,  10'd0, 3'd0, OTHERS_HIT));
    directed.push_back(mk_req(ACT_PROC_WRITE,  10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_INV,   10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_READ,  10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_PROC_READ,   10'd0, 3'd0, OTHERS_HITM));
    directed.push_back(mk_req(ACT_SNOOP_WRITE, 10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_READ,  10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_PROC_WRITE,  10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_READ,  10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_RWIM,  10'd0, 3'd0, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_PROC_WRITE,  10'd1023, 3'd7, OTHERS_SPARE));
    directed.push_back(mk_req(ACT_RESERVED,    10'd1023, 3'd7, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_SNOOP_RWIM,  10'd1023, 3'd7, OTHERS_NOHIT));
    directed.push_back(mk_req(ACT_PROC_READ,   10'd1023, 3'd7, OTHERS_SPARE));
    directed.push_back(mk_req(ACT_SNOOP_RWIM,  10'd1023, 3'd7, OTHERS_NOHIT));

    send_idle_pct = 35;
    stall_pct <= 88;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_req(directed[i]);
    drain();

    for (int p = 0; p < 3; p++) begin
      unique case (p)
        0: begin
          send_idle_pct = 35;
          stall_pct <= 88;
        end
        1: begin
          send_idle_pct = 88;
          stall_pct <= 35;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly a small pool of lines, so that each one can climb through all states
        pick = $urandom_range(POOL_SIZE - 1);
        r.action = 3'($urandom_range(7));
        r.others_snoop_result = 2'($urandom_range(3));
        if ($urandom_range(9) == 0) begin
          r.set_index = 10'($urandom_range(1023));
          r.way = 3'($urandom_range(7));
        end else begin
          r.set_index = pool_set[pick];
          r.way = pool_way[pick];
        end
        send_req(r);
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** moesi_line_state_machine: PASSED **");
    end else begin
      $display("** moesi_line_state_machine: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** moesi_line_state_machine: FAILED **");
    $finish;
  end

endmodule
